>>> hdl/bounded_doubly_linked_list_top_assert.svh
// Assertion macros for the list engine top level.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define BDLL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define BDLL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDLL_ASSERT(label, prop, msg)
`define BDLL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hdl/bdll_pkg.sv
package bdll_pkg;

    localparam int DATA_W       = 32;
    localparam int TYPE_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int CAPACITY_DEF = 16;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_DELETE     = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_LIST_FWD   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_LIST_BWD   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ITEM     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_ROT_LEFT,
        CMD_DROP_HEAD,
        CMD_ROT_RIGHT
    } cell_cmd_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] value;
    } cell_link_t;

endpackage

>>> hdl/bdll_cell.sv
module bdll_cell
    import bdll_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    input  cell_link_t               left,
    input  cell_link_t               right,
    input  logic signed [DATA_W-1:0] head_value,
    input  logic signed [DATA_W-1:0] tail_value,
    input  logic signed [DATA_W-1:0] new_value,
    output cell_link_t               cell_q
);

    logic                     occ_reg;
    logic                     occ_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        occ_next   = occ_reg;
        value_next = value_reg;
        unique case (cmd)
            CMD_HOLD:
            begin
            end
            CMD_PUSH_FRONT:
            begin
                // whole occupied run moves one cell toward the back
                if (left.occ)
                begin
                    occ_next   = 1'b1;
                    value_next = left.value;
                end
            end
            CMD_PUSH_BACK:
            begin
                // first empty cell takes the new value
                if (!occ_reg && left.occ)
                begin
                    occ_next   = 1'b1;
                    value_next = new_value;
                end
            end
            CMD_ROT_LEFT:
            begin
                if (occ_reg)
                    value_next = right.occ ? right.value : head_value;
            end
            CMD_DROP_HEAD:
            begin
                // head leaves the ring; last occupied cell empties
                if (occ_reg)
                begin
                    if (right.occ)
                        value_next = right.value;
                    else
                        occ_next = 1'b0;
                end
            end
            CMD_ROT_RIGHT:
            begin
                if (occ_reg)
                    value_next = left.occ ? left.value : tail_value;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign cell_q.occ   = occ_reg;
    assign cell_q.value = value_reg;

endmodule

>>> hdl/bounded_doubly_linked_list_top.sv
// Bounded list engine. Holds up to CAPACITY signed 32-bit values in order,
// front to back, in a row of cells: cell 0 is the front, the occupied cells
// always form one unbroken run from cell 0, and every cell only talks to its
// two neighbors, the broadcast command and new value, and two shared buses
// (front value and back value). Requests arrive on the req channel
// (req_type, req_value); results leave on the res channel through a one-entry
// output register. A held result pauses execution, not request intake.
// Operations, with n the number of values held at the time of the request:
//   insert front / back : accept, then one shift of the chain;
//                         a full list answers with the full status instead.
//   delete              : the run rotates one cell per cycle while the output
//                         is free (n steps), so every value passes the front
//                         once and is compared there; the first match leaves
//                         the ring as it passes; after n steps the order is
//                         restored. One done or not-found result at the end.
//   list forward/back   : one item result per rotation step,
//                         front-to-back (rotate toward the front, read cell 0)
//                         or back-to-front (rotate toward the back, read the
//                         last occupied cell); the final item is marked last.
//                         An empty list gives one empty-status result.
//   unknown type codes  : accepted and dropped, no result.
// The chain rotation, one cell per cycle while the output is free, sets the
// delete and listing time. A new request is taken only while the engine is
// idle. Reset empties the list at once; there is no clearing pass.
module bounded_doubly_linked_list_top
    import bdll_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [TYPE_W-1:0]          req_type,
    input  logic signed [DATA_W-1:0]   req_value,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic signed [DATA_W-1:0]   item_value,
    output logic [STATUS_W-1:0]        result_status,
    output logic                       last_result
);

`include "bounded_doubly_linked_list_top_assert.svh"

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } state_t;

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    state_t                     state_reg,     state_next;
    logic [TYPE_W-1:0]          req_type_reg,  req_type_next;
    logic signed [DATA_W-1:0]   req_value_reg, req_value_next;
    logic [CNT_W-1:0]           count_reg,     count_next;
    logic [STEP_W-1:0]          step_reg,      step_next;
    logic                       found_reg,     found_next;

    // output register
    logic                       res_valid_reg,  res_valid_next;
    logic signed [DATA_W-1:0]   item_value_reg, item_value_next;
    logic [STATUS_W-1:0]        status_reg,     status_next;
    logic                       last_reg,       last_next;

    // ---------------------------------------------------------------
    // cell chain
    // ---------------------------------------------------------------
    cell_cmd_t                  cmd;
    cell_link_t                 cell_q     [CAPACITY];
    cell_link_t                 left_link  [CAPACITY];
    cell_link_t                 right_link [CAPACITY];
    logic [CAPACITY-1:0]        occ_vec;
    logic signed [DATA_W-1:0]   head_value;
    logic signed [DATA_W-1:0]   tail_value;

    assign head_value = cell_q[0].value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_front
                // the front cell sees the new value on its left during a push
                assign left_link[gi].occ   = (cmd == CMD_PUSH_FRONT) ||
                                             (cmd == CMD_PUSH_BACK);
                assign left_link[gi].value = req_value_reg;
            end
            else
            begin : g_inner_l
                assign left_link[gi] = cell_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_back
                assign right_link[gi].occ   = 1'b0;
                assign right_link[gi].value = '0;
            end
            else
            begin : g_inner_r
                assign right_link[gi] = cell_q[gi+1];
            end

            assign occ_vec[gi] = cell_q[gi].occ;

            bdll_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left       (left_link[gi]),
                .right      (right_link[gi]),
                .head_value (head_value),
                .tail_value (tail_value),
                .new_value  (req_value_reg),
                .cell_q     (cell_q[gi])
            );
        end
    endgenerate

    // back value bus: the last occupied cell is the one whose right is empty
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_q[i].occ && !right_link[i].occ)
                tail_value = tail_value | cell_q[i].value;
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic out_free;
    logic last_step;
    logic head_match;

    assign out_free   = !res_valid_reg || !res_stall;
    assign last_step  = (CNT_W'(step_reg) == (count_reg - CNT_W'(1)));
    assign head_match = (head_value == req_value_reg);

    always_comb
    begin
        state_next      = state_reg;
        req_type_next   = req_type_reg;
        req_value_next  = req_value_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        cmd             = CMD_HOLD;
        res_valid_next  = res_valid_reg && res_stall;
        item_value_next = item_value_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_type_next  = req_type;
                    req_value_next = req_value;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    step_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_IDLE;
                    unique case (req_type_reg) inside
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            res_valid_next  = 1'b1;
                            item_value_next = '0;
                            last_next       = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY))
                                status_next = STAT_FULL;
                            else
                            begin
                                status_next = STAT_DONE;
                                cmd = (req_type_reg == REQ_PUSH_FRONT) ?
                                      CMD_PUSH_FRONT : CMD_PUSH_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                item_value_next = '0;
                                status_next     = STAT_NOTFOUND;
                                last_next       = 1'b1;
                            end
                            else
                                state_next = ST_WALK;
                        end
                        REQ_LIST_FWD, REQ_LIST_BWD:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                item_value_next = '0;
                                status_next     = STAT_EMPTY;
                                last_next       = 1'b1;
                            end
                            else
                                state_next = ST_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    unique case (req_type_reg) inside
                        REQ_LIST_FWD:
                        begin
                            cmd             = CMD_ROT_LEFT;
                            res_valid_next  = 1'b1;
                            item_value_next = head_value;
                            status_next     = STAT_ITEM;
                            last_next       = last_step;
                        end
                        REQ_LIST_BWD:
                        begin
                            cmd             = CMD_ROT_RIGHT;
                            res_valid_next  = 1'b1;
                            item_value_next = tail_value;
                            status_next     = STAT_ITEM;
                            last_next       = last_step;
                        end
                        REQ_DELETE:
                        begin
                            if (!found_reg && head_match)
                            begin
                                cmd        = CMD_DROP_HEAD;
                                found_next = 1'b1;
                            end
                            else
                                cmd = CMD_ROT_LEFT;
                            if (last_step)
                            begin
                                res_valid_next  = 1'b1;
                                item_value_next = '0;
                                last_next       = 1'b1;
                                status_next     = found_next ? STAT_DONE : STAT_NOTFOUND;
                                if (found_next)
                                    count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (last_step)
                        state_next = ST_IDLE;
                    else
                        step_next = step_reg + STEP_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_type_reg   <= REQ_PUSH_FRONT;
            req_value_reg  <= '0;
            count_reg      <= '0;
            step_reg       <= '0;
            found_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
            item_value_reg <= '0;
            status_reg     <= STAT_DONE;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            req_type_reg   <= req_type_next;
            req_value_reg  <= req_value_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            res_valid_reg  <= res_valid_next;
            item_value_reg <= item_value_next;
            status_reg     <= status_next;
            last_reg       <= last_next;
        end
    end

    assign req_stall     = (state_reg != ST_IDLE);
    assign res_valid     = res_valid_reg;
    assign item_value    = item_value_reg;
    assign result_status = status_reg;
    assign last_result   = last_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // occupied cells always form one run starting at the front cell
    `BDLL_ASSERT_ALWAYS(a_occ_contiguous, (((occ_vec + CAPACITY'(1)) & occ_vec) == '0), "occupied cells not contiguous")
    // between requests the count agrees with the chain
    `BDLL_ASSERT(a_count_matches, (state_reg == ST_IDLE) |-> ($countones(occ_vec) == int'(count_reg)), "count and occupied cells disagree")
    // a delete walk removes at most one value
    `BDLL_ASSERT(a_single_drop, (cmd == CMD_DROP_HEAD) |-> !found_reg, "second removal within one delete")

endmodule
